// ===== design/crr_pkg.sv =====
// Shared codes and fixed widths for the capture ring readout block.
`timescale 1ns / 1ps

package crr_pkg;

  // Operation codes on func
  localparam logic [1:0] FN_STORE  = 2'd0;
  localparam logic [1:0] FN_LOCATE = 2'd1;
  localparam logic [1:0] FN_READ   = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_RLE_MODE     = 3'd0;
  localparam logic [2:0] CFG_PRE_COUNT    = 3'd1;
  localparam logic [2:0] CFG_POST_COUNT   = 3'd2;
  localparam logic [2:0] CFG_TRIGGER_ADDR = 3'd3;
  localparam logic [2:0] CFG_LAST_ADDR    = 3'd4;

  // Field widths
  localparam int WORD_W  = 16;
  localparam int COUNT_W = 15;
  localparam int ADDR_W  = 14;
  localparam int CFG_W   = 15;

  // Operand width of the ring-address reducer (start plus index, or a count)
  localparam int MOD_W = 17;

endpackage

// ===== design/capture_ring_readout_unit.sv =====
// Capture ring readout: ring memory, window locate sequencer and readout.
`timescale 1ns / 1ps

// A store, an unknown op or a read outside the window gives its result the cycle
//   after start; a read inside the window goes through iterative address reduction, then
//   one memory read; a plain locate runs the reduction twice (trigger, then pre count).
// Throughput: one op at a time; an RLE locate walks the ring one entry a cycle through
//   the single read port.
// Results are strobed on done for one cycle and cannot be stalled; busy is low then.
// Reset clears configuration and window state; ring contents are undefined until stored.
module capture_ring_readout_unit #(
  parameter int BUF_LEN = 16384
) (
  input  logic                          clk,
  input  logic                          rst,
  // command side
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func,
  input  logic [crr_pkg::ADDR_W-1:0]    mem_addr,
  input  logic [crr_pkg::WORD_W-1:0]    capture_word,
  input  logic [crr_pkg::ADDR_W-1:0]    read_index,
  // result side
  output logic                          done,
  output logic [crr_pkg::WORD_W-1:0]    read_word,
  output logic [crr_pkg::COUNT_W-1:0]   sample_count,
  output logic [crr_pkg::COUNT_W-1:0]   trigger_pos,
  output logic                          error,
  // configuration
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_index,
  input  logic [crr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int AW = $clog2(BUF_LEN);
  localparam int NW = AW + 1;               // entry counter, holds BUF_LEN itself
  localparam int SW = AW + 9;               // run-length sum over the whole ring
  localparam int CW = (SW > 17) ? SW : 17;  // compare width for sum against counts
  localparam int MW = crr_pkg::MOD_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MOD_A = 5'b00010,
    ST_MOD_B = 5'b00100,
    ST_FETCH = 5'b01000,
    ST_WALK  = 5'b10000
  } st_t;

  st_t state;

  // Configuration registers
  logic                         rle_mode;
  logic [crr_pkg::COUNT_W-1:0]  pre_count;
  logic [crr_pkg::COUNT_W-1:0]  post_count;
  logic [crr_pkg::ADDR_W-1:0]   trigger_addr;
  logic [crr_pkg::ADDR_W-1:0]   last_addr;

  // Window state
  logic [AW-1:0]                window_start;
  logic [crr_pkg::COUNT_W-1:0]  window_count;
  logic [7:0]                   first_excess;
  logic [crr_pkg::COUNT_W-1:0]  rle_trigger_index;
  logic                         walk_failed;

  // Op context
  logic [1:0]                   op;
  logic                         idx_zero;
  logic [AW-1:0]                trig_hold;

  // Walk registers
  logic [AW-1:0]                pos;
  logic [AW-1:0]                data_pos;
  logic                         pend;
  logic [SW-1:0]                sum;
  logic [NW-1:0]                n;
  logic                         trig_found;
  logic [NW-1:0]                trig_i;

  // Ring memory
  logic [crr_pkg::WORD_W-1:0]   mem [BUF_LEN];
  logic [crr_pkg::WORD_W-1:0]   mem_q;
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;

  // Reducer
  logic                         mod_start;
  logic [MW-1:0]                mod_value;
  logic                         mod_done;
  logic [AW-1:0]                mod_result;

  logic                         accept;
  logic                         out_of_window;
  logic                         store_in_range;

  // Walk datapath
  logic [8:0]                   run_len;
  logic [SW-1:0]                sum_next;
  logic [NW-1:0]                n_next;
  logic [CW-1:0]                sum_c;
  logic [CW-1:0]                total_c;
  logic [CW-1:0]                level_c;
  logic                         trig_hit;
  logic [NW-1:0]                trig_i_eff;
  logic                         reach;
  logic                         last_entry;
  logic [crr_pkg::COUNT_W-1:0]  count_sat;
  logic [AW-1:0]                pos_prev;

  // Plain locate datapath
  logic [AW:0]                  back_diff;
  logic [AW-1:0]                plain_start;
  logic [15:0]                  plain_total;
  logic [crr_pkg::COUNT_W-1:0]  plain_count;

  logic [crr_pkg::WORD_W-1:0]   fetch_word;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Status fields follow the window registers; they hold through the done cycle
  assign sample_count = window_count;
  assign trigger_pos  = rle_trigger_index;

  assign out_of_window  = ({1'b0, read_index} >= window_count);
  assign store_in_range = (MW'(mem_addr) < MW'(BUF_LEN));

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_mode     <= 1'b0;
      pre_count    <= '0;
      post_count   <= '0;
      trigger_addr <= '0;
      last_addr    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        crr_pkg::CFG_RLE_MODE:     rle_mode     <= cfg_data[0];
        crr_pkg::CFG_PRE_COUNT:    pre_count    <= cfg_data;
        crr_pkg::CFG_POST_COUNT:   post_count   <= cfg_data;
        crr_pkg::CFG_TRIGGER_ADDR: trigger_addr <= cfg_data[crr_pkg::ADDR_W-1:0];
        crr_pkg::CFG_LAST_ADDR:    last_addr    <= cfg_data[crr_pkg::ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Ring memory: one write port for stores, one registered read port shared
  // by the walk and by window reads
  // ---------------------------------------------------------------------------
  assign mem_we    = accept && (func == crr_pkg::FN_STORE) && store_in_range;
  assign mem_waddr = AW'(mem_addr);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = pos;
    if (state == ST_WALK) begin
      mem_re = 1'b1;
    end else if ((state == ST_MOD_A) && mod_done && (op == crr_pkg::FN_READ)) begin
      mem_re    = 1'b1;
      mem_raddr = mod_result;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= capture_word;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Address reducer: trigger, last address, pre count and start plus index
  // all go modulo the ring length through here
  // ---------------------------------------------------------------------------
  always_comb begin
    mod_start = 1'b0;
    mod_value = MW'(trigger_addr);
    if (accept && (func == crr_pkg::FN_LOCATE)) begin
      mod_start = 1'b1;
      mod_value = rle_mode ? MW'(last_addr) : MW'(trigger_addr);
    end else if (accept && (func == crr_pkg::FN_READ) && !out_of_window) begin
      mod_start = 1'b1;
      mod_value = MW'(window_start) + MW'(read_index);
    end else if ((state == ST_MOD_A) && mod_done && (op == crr_pkg::FN_LOCATE)
                 && !rle_mode) begin
      mod_start = 1'b1;
      mod_value = MW'(pre_count);
    end
  end

  crr_mod_unit #(
    .BUF_LEN (BUF_LEN)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .value  (mod_value),
    .done   (mod_done),
    .result (mod_result)
  );

  // ---------------------------------------------------------------------------
  // RLE walk: data read last cycle is summed this cycle, newest entry first
  // ---------------------------------------------------------------------------
  assign run_len    = {1'b0, mem_q[15:8]} + 9'd1;
  assign sum_next   = sum + SW'(run_len);
  assign n_next     = n + 1'b1;
  assign sum_c      = CW'(sum_next);
  assign total_c    = CW'(pre_count) + CW'(post_count);
  assign level_c    = CW'(post_count) - 1'b1;
  // A zero post count puts the trigger level at the top of the compare-width range: never hit
  assign trig_hit   = !trig_found && (post_count != '0) && (sum_c >= level_c);
  assign trig_i_eff = trig_hit ? n_next : trig_i;
  assign reach      = (sum_c >= total_c);
  assign last_entry = (n_next == NW'(BUF_LEN));
  assign count_sat  = (32'(n_next) > 32'h7FFF) ? 15'h7FFF : crr_pkg::COUNT_W'(n_next);
  assign pos_prev   = (pos == '0) ? AW'(BUF_LEN - 1) : pos - 1'b1;

  // ---------------------------------------------------------------------------
  // Plain locate: start = trigger - pre, wrapped once into the ring
  // ---------------------------------------------------------------------------
  assign back_diff   = {1'b0, trig_hold} - {1'b0, mod_result};
  assign plain_start = back_diff[AW] ? AW'(back_diff + (AW + 1)'(BUF_LEN))
                                     : back_diff[AW-1:0];
  assign plain_total = {1'b0, pre_count} + {1'b0, post_count};
  assign plain_count = plain_total[15] ? 15'h7FFF : plain_total[14:0];

  // First window word carries the excess off its length byte
  assign fetch_word = idx_zero ? {mem_q[15:8] - first_excess, mem_q[7:0]} : mem_q;

  // ---------------------------------------------------------------------------
  // Sequencer and window state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      done              <= 1'b0;
      window_start      <= '0;
      window_count      <= '0;
      first_excess      <= '0;
      rle_trigger_index <= '0;
      walk_failed       <= 1'b0;
      pend              <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if ((func == crr_pkg::FN_LOCATE) ||
                ((func == crr_pkg::FN_READ) && !out_of_window)) begin
              state <= ST_MOD_A;
            end else begin
              // store, unknown op, or read past the window: report now
              done <= 1'b1;
            end
          end
        end
        ST_MOD_A: begin
          if (mod_done) begin
            if (op == crr_pkg::FN_READ) begin
              state <= ST_FETCH;
            end else if (rle_mode) begin
              pend  <= 1'b0;
              state <= ST_WALK;
            end else begin
              state <= ST_MOD_B;
            end
          end
        end
        ST_MOD_B: begin
          if (mod_done) begin
            window_start      <= plain_start;
            window_count      <= plain_count;
            first_excess      <= '0;
            rle_trigger_index <= crr_pkg::COUNT_W'(trig_hold);
            walk_failed       <= 1'b0;
            done              <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        ST_FETCH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        ST_WALK: begin
          pend <= 1'b1;
          if (pend) begin
            if (reach) begin
              window_start      <= data_pos;
              window_count      <= count_sat;
              first_excess      <= sum_next[7:0] - total_c[7:0];
              rle_trigger_index <= crr_pkg::COUNT_W'(n_next - trig_i_eff);
              walk_failed       <= 1'b0;
              done              <= 1'b1;
              state             <= ST_IDLE;
            end else if (last_entry) begin
              // full pass short of the total: empty window
              window_start      <= '0;
              window_count      <= '0;
              first_excess      <= '0;
              rle_trigger_index <= '0;
              walk_failed       <= 1'b1;
              done              <= 1'b1;
              state             <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Op context, walk datapath and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op       <= func;
      idx_zero <= (read_index == '0);
    end
    if ((state == ST_MOD_A) && mod_done) begin
      trig_hold  <= mod_result;
      pos        <= mod_result;
      sum        <= '0;
      n          <= '0;
      trig_found <= 1'b0;
      trig_i     <= '0;
    end else if (state == ST_WALK) begin
      // advance the read address every cycle; hold the address of the data in flight
      pos      <= pos_prev;
      data_pos <= pos;
      if (pend) begin
        sum    <= sum_next;
        n      <= n_next;
        trig_i <= trig_i_eff;
        if (trig_hit) begin
          trig_found <= 1'b1;
        end
      end
    end

    case (state)
      ST_IDLE: begin
        read_word <= '0;
        error     <= walk_failed || ((func == crr_pkg::FN_READ) && out_of_window);
      end
      ST_MOD_B: begin
        read_word <= '0;
        error     <= 1'b0;
      end
      ST_FETCH: begin
        read_word <= fetch_word;
        error     <= walk_failed;
      end
      ST_WALK: begin
        read_word <= '0;
        error     <= !reach;
      end
      default: begin
        read_word <= '0;
        error     <= walk_failed;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while the sequencer is busy");

  a_store_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == crr_pkg::FN_STORE)) |=> (done && !busy))
    else $error("store did not report on the next cycle");

  a_fetch_after_reduce: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (($past(state) == ST_MOD_A) && $past(mod_done)))
    else $error("window read fetched without a reduced address");

  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (n < NW'(BUF_LEN)))
    else $error("ring walk ran past one full pass");

  a_walk_failed_empty: assert property (@(posedge clk) disable iff (rst)
    walk_failed |-> (window_count == '0))
    else $error("failed walk left a non-empty window");

endmodule

// ===== design/crr_mod_unit.sv =====
// Iterative reduction of an address or count modulo the ring length.
`timescale 1ns / 1ps

module crr_mod_unit #(
  parameter int BUF_LEN = 16384
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [crr_pkg::MOD_W-1:0]  value,
  output logic                       done,
  output logic [$clog2(BUF_LEN)-1:0] result
);

  localparam int AW = $clog2(BUF_LEN);
  localparam int K  = crr_pkg::MOD_W - AW;
  localparam int KW = $clog2(K + 1);
  localparam logic [crr_pkg::MOD_W-1:0] BASE = crr_pkg::MOD_W'(BUF_LEN);

  logic [crr_pkg::MOD_W-1:0] v;
  logic [crr_pkg::MOD_W-1:0] sub;
  logic [KW-1:0]             k;
  logic                      active;

  // Subtract the ring length scaled by 2^k, largest scale first
  assign sub    = BASE << k;
  assign result = v[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= active && (k == '0);
      if (start) begin
        active <= 1'b1;
      end else if (active && (k == '0)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v <= value;
      k <= KW'(K);
    end else if (active) begin
      if (v >= sub) begin
        v <= v - sub;
      end
      if (k != '0) begin
        k <= k - 1'b1;
      end
    end
  end

endmodule

// ===== tb/readout_scoreboard_pkg.sv =====
// Readout predictor and result scoreboard for the capture ring readout testbench.
`timescale 1ns / 1ps

package readout_scoreboard_pkg;
  import crr_pkg::*;

  localparam int RING_LEN = 16384;
  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 15'h7fff;
  localparam logic [CFG_W-1:0] COUNT_FULL = CFG_W'(RING_LEN);
  localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(RING_LEN - 1);

  typedef struct packed {
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] trig_pos;
    logic               err;
  } readout_t;

  class readout_scoreboard;
    bit               rle_mode;
    bit [CFG_W-1:0]   pre_count;
    bit [CFG_W-1:0]   post_count;
    bit [ADDR_W-1:0]  trigger_addr;
    bit [ADDR_W-1:0]  last_addr;

    bit [WORD_W-1:0]  ring [RING_LEN];
    bit [ADDR_W-1:0]  win_start;
    bit [COUNT_W-1:0] win_count;
    bit [7:0]         excess;
    bit [COUNT_W-1:0] trig_index;
    bit               walk_failed;

    readout_t expected_q[$];
    int error_count;

    function new();
      error_count = 0;
    endfunction

    function void set_register(logic [2:0] index, logic [CFG_W-1:0] data);
      case (index)
        CFG_RLE_MODE:     rle_mode = data[0];
        CFG_PRE_COUNT:    pre_count = data;
        CFG_POST_COUNT:   post_count = data;
        CFG_TRIGGER_ADDR: trigger_addr = data[ADDR_W-1:0];
        CFG_LAST_ADDR:    last_addr = data[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    // Walk back from the last written word, summing run lengths until the window fills.
    function void locate_rle();
      bit [31:0] total;
      bit [31:0] trig_level;
      bit [31:0] sum;
      bit [ADDR_W-1:0] pos;
      int unsigned trig_i;
      bit trig_found;
      int unsigned n;
      total = 32'(pre_count) + 32'(post_count);
      trig_level = 32'(post_count) - 32'd1;
      pos = last_addr;
      sum = '0;
      trig_i = 0;
      trig_found = 1'b0;
      for (n = 1; n <= RING_LEN; n++) begin
        sum = sum + 32'(ring[pos][15:8]) + 32'd1;
        if (!trig_found && sum >= trig_level) begin
          trig_i = n;
          trig_found = 1'b1;
        end
        if (sum >= total) begin
          win_start = pos;
          win_count = (n > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(n);
          excess = 8'(sum - total);
          trig_index = COUNT_W'(n - trig_i);
          walk_failed = 1'b0;
          return;
        end
        pos = pos - 1'b1;
      end
      // whole ring too short: empty window
      win_start = '0;
      win_count = '0;
      excess = '0;
      trig_index = '0;
      walk_failed = 1'b1;
    endfunction

    function void locate_plain();
      int unsigned span;
      span = int'(pre_count) + int'(post_count);
      win_start = trigger_addr - ADDR_W'(pre_count);
      win_count = (span > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(span);
      excess = '0;
      trig_index = COUNT_W'(trigger_addr);
      walk_failed = 1'b0;
    endfunction

    function void note_command(logic [1:0] f, logic [ADDR_W-1:0] addr,
                               logic [WORD_W-1:0] word, logic [ADDR_W-1:0] idx);
      readout_t r;
      r.word = '0;
      r.err = walk_failed;
      case (f)
        FN_STORE: ring[addr] = word;
        FN_LOCATE: begin
          if (rle_mode) begin
            locate_rle();
          end else begin
            locate_plain();
          end
          r.err = walk_failed;
        end
        FN_READ: begin
          if (COUNT_W'(idx) >= win_count) begin
            r.err = 1'b1;
          end else begin
            r.word = ring[ADDR_W'(win_start + idx)];
            if (idx == '0) r.word = r.word - {excess, 8'h00};
          end
        end
        default: ;
      endcase
      r.count = win_count;
      r.trig_pos = trig_index;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [WORD_W-1:0] word, logic [COUNT_W-1:0] count,
                               logic [COUNT_W-1:0] trig, logic err);
      readout_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result strobed with no command outstanding");
        error_count++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (word !== exp_r.word) begin
        $error("read_word: expected %h, got %h", exp_r.word, word);
        error_count++;
      end
      if (count !== exp_r.count) begin
        $error("sample_count: expected %0d, got %0d", exp_r.count, count);
        error_count++;
      end
      if (trig !== exp_r.trig_pos) begin
        $error("trigger_pos: expected %0d, got %0d", exp_r.trig_pos, trig);
        error_count++;
      end
      if (err !== exp_r.err) begin
        $error("error: expected %b, got %b", exp_r.err, err);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        $error("%0d expected results never arrived", expected_q.size());
        error_count++;
      end
    endfunction
  endclass

endpackage

// ===== tb/capture_ring_readout_unit_tb.sv =====
// Self-checking testbench for the capture ring readout unit.
`timescale 1ns / 1ps

module capture_ring_readout_unit_tb;
  import crr_pkg::*;
  import readout_scoreboard_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 9;
  // An RLE walk can take a full ring pass; allow several of those with no transfer.
  localparam int IDLE_LIMIT = 80000;
  localparam int PHASES = 10;
  localparam int PHASE_ITEMS = 125;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // command side
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        func = FN_STORE;
  logic [ADDR_W-1:0] mem_addr = '0;
  logic [WORD_W-1:0] capture_word = '0;
  logic [ADDR_W-1:0] read_index = '0;

  // result side
  logic               done;
  logic [WORD_W-1:0]  read_word;
  logic [COUNT_W-1:0] sample_count;
  logic [COUNT_W-1:0] trigger_pos;
  logic               error;

  // configuration
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = CFG_RLE_MODE;
  logic [CFG_W-1:0] cfg_data = '0;

  readout_scoreboard sb;
  int unsigned burst_left = 0;
  int idle_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  capture_ring_readout_unit #(
    .BUF_LEN(RING_LEN)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .mem_addr(mem_addr),
    .capture_word(capture_word),
    .read_index(read_index),
    .done(done),
    .read_word(read_word),
    .sample_count(sample_count),
    .trigger_pos(trigger_pos),
    .error(error),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Results cannot be held off: check every strobe against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(read_word, sample_count, trigger_pos, error);
  end

  // Watchdog: count cycles with neither a command transfer nor a result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Issue one command after a random gap and hold it until the transfer.
  // Called at a clock edge; start stays high into the next command when the gap is zero.
  task automatic send_cmd(input logic [1:0] f, input logic [ADDR_W-1:0] a,
                          input logic [WORD_W-1:0] w, input logic [ADDR_W-1:0] i);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(99);
    if (burst_left != 0) begin
      burst_left--;
      gap = 0;
    end else if (r < 3) begin
      // start a stretch of back-to-back commands
      burst_left = $urandom_range(80, 20);
      gap = 0;
    end else if (r < 50) begin
      gap = 0;
    end else if (r < 80) begin
      gap = $urandom_range(3, 1);
    end else if (r < 95) begin
      gap = $urandom_range(12, 4);
    end else begin
      gap = $urandom_range(100, 20);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    mem_addr <= a;
    capture_word <= w;
    read_index <= i;
    do @(posedge clk); while (busy);
    sb.note_command(f, a, w, i);
  endtask

  // Drop start and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write all five registers with the block idle.
  task automatic write_registers(input logic rle, input logic [CFG_W-1:0] pre,
                                 input logic [CFG_W-1:0] post,
                                 input logic [ADDR_W-1:0] trig,
                                 input logic [ADDR_W-1:0] last);
    logic [2:0]       idx [5];
    logic [CFG_W-1:0] val [5];
    idx = '{CFG_RLE_MODE, CFG_PRE_COUNT, CFG_POST_COUNT, CFG_TRIGGER_ADDR, CFG_LAST_ADDR};
    val = '{CFG_W'(rle), pre, post, CFG_W'(trig), CFG_W'(last)};
    drain();
    for (int k = 0; k < 5; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_data <= val[k];
      @(posedge clk);
      sb.set_register(idx[k], val[k]);
    end
    cfg_we <= 1'b0;
  endtask

  // Window sizes: mostly small; plain mode also reaches the full range.
  // RLE totals stay moderate so each walk ends well inside one ring pass.
  function automatic logic [CFG_W-1:0] pick_count(input logic rle);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return CFG_W'($urandom_range(40, 0));
    if (r < 85 || rle) return CFG_W'($urandom_range(rle ? 2000 : 1000, 0));
    if (r < 95) return CFG_W'($urandom_range(RING_LEN, 0));
    return r[0] ? COUNT_FULL : '0;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return ADDR_TOP;
    return ADDR_W'($urandom_range(RING_LEN - 1, 0));
  endfunction

  initial begin
    logic              rle_sel;
    logic [1:0]        f;
    logic [ADDR_W-1:0] a;
    logic [WORD_W-1:0] w;
    logic [ADDR_W-1:0] i;
    int unsigned       r;
    int unsigned       lim;

    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole ring with unit-length words so no read or walk touches an
    // unwritten entry; one full pass then sums to exactly the ring length.
    for (int k = 0; k < RING_LEN; k++) begin
      send_cmd(FN_STORE, ADDR_W'(k), {8'h00, 8'($urandom)}, ADDR_W'($urandom));
    end

    // Reset configuration: plain mode, empty window, read beyond it, unknown op.
    send_cmd(FN_LOCATE, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, '0);
    send_cmd(FN_UNUSED, '1, '1, '1);

    // Largest plain window: count saturates, start wraps to the top of the ring.
    write_registers(1'b0, COUNT_FULL, COUNT_FULL, ADDR_TOP, '0);
    send_cmd(FN_STORE, ADDR_TOP, 16'hffff, '0);
    send_cmd(FN_STORE, '0, 16'h0000, '1);
    send_cmd(FN_LOCATE, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, ADDR_TOP);

    // RLE total above a full pass: the walk fails and the flag rides on every result.
    write_registers(1'b1, COUNT_FULL, COUNT_FULL, ADDR_TOP, '0);
    send_cmd(FN_LOCATE, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, '0);
    send_cmd(FN_STORE, ADDR_W'(2), 16'h02ab, '0);

    // Short RLE walk across the ring end, with excess on the oldest entry.
    write_registers(1'b1, CFG_W'(4), CFG_W'(3), ADDR_TOP, '0);
    send_cmd(FN_STORE, '0, 16'h0405, '0);
    send_cmd(FN_LOCATE, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, '0);
    send_cmd(FN_READ, '0, '0, ADDR_W'(1));
    send_cmd(FN_READ, '0, '0, ADDR_W'(2));

    // Zero post count: the trigger level wraps and is never reached.
    write_registers(1'b1, CFG_W'(4), '0, ADDR_TOP, '0);
    send_cmd(FN_LOCATE, '0, '0, '0);

    // Back to plain mode without a locate: the stale excess still adjusts word 0.
    write_registers(1'b0, CFG_W'(4), '0, ADDR_TOP, '0);
    send_cmd(FN_READ, '0, '0, '0);

    // Random phases, alternating plain and RLE. RLE phases mostly build runs just
    // behind the last written address so the walk sees varied lengths.
    for (int p = 0; p < PHASES; p++) begin
      rle_sel = p[0];
      write_registers(rle_sel, pick_count(rle_sel), pick_count(rle_sel), pick_addr(),
                      pick_addr());
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        a = ADDR_W'($urandom);
        w = WORD_W'($urandom);
        i = ADDR_W'($urandom);
        if (r < 35) begin
          f = FN_STORE;
          if (rle_sel) begin
            a = sb.last_addr - ADDR_W'($urandom_range(63, 0));
            if ($urandom_range(1) == 1) w[15:8] = 8'($urandom_range(7, 0));
          end
        end else if (r < 45) begin
          f = FN_LOCATE;
        end else if (r < 93) begin
          f = FN_READ;
          // keep most reads inside the window, often on the adjusted first word
          if (sb.win_count != '0 && r < 85) begin
            lim = (int'(sb.win_count) > RING_LEN) ? RING_LEN : int'(sb.win_count);
            if ($urandom_range(3) == 0) begin
              i = '0;
            end else begin
              i = ADDR_W'($urandom_range(lim - 1, 0));
            end
          end
        end else if (r < 97) begin
          f = FN_UNUSED;
        end else begin
          // stray store anywhere in the ring
          f = FN_STORE;
        end
        send_cmd(f, a, w, i);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.flag_leftovers();
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
